// ----- hdl/asp_pkg.sv -----
`timescale 1ns / 1ps

package asp_pkg;

   localparam int COUNT_W     = 13;
   localparam int MAX_RESULTS = 5;
   localparam int MAX_HELD    = 4;
   localparam int NDATA_W     = 3;
   localparam int NRES_W      = 3;

   localparam int DEF_MAX_ANNOT = 256;
   localparam int DEF_MAX_CHUNK = 4096;
   localparam int COUNT_CAP     = 8191;

   localparam logic [7:0] CH_SUB = 8'h1A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;

   localparam logic [1:0] KIND_DATA      = 2'd0;
   localparam logic [1:0] KIND_ANNOT     = 2'd1;
   localparam logic [1:0] KIND_ANNOT_END = 2'd2;
   localparam logic [1:0] KIND_CHUNK_END = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       chunk_last;
   } asp_req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         out_byte;
      logic [COUNT_W-1:0] count;
      logic               overflow;
      logic               last;
   } asp_rsp_type;

   // all results caused by one transaction, in delivery order from slot 0
   typedef struct packed {
      asp_rsp_type [MAX_RESULTS-1:0] slot;
      logic [NRES_W-1:0]             cnt;
   } asp_batch_type;

endpackage

// ----- hdl/annotation_stream_splitter.sv -----
`timescale 1ns / 1ps

// Splits a debugger byte stream into data bytes and framed annotations.
// Input channel req_*: one byte per transaction plus a chunk_last flag.
// Result channel rsp_*: kind, byte, count, overflow and a last flag that
// marks the final result caused by one input transaction.
// An input transaction causes 0 to 5 results. They are computed in the
// accepting cycle and held in a five-entry output buffer; the first one
// is offered on rsp_* the cycle after acceptance, one per cycle after that while rsp_ready is high.
// Throughput: one input per cycle while each input gives at most one result
// and rsp_ready is high; an input with k results holds the output until all
// k are taken; the next input is taken in the cycle its last one is taken.
// Inputs that give no result are taken without touching the buffer.
// When the receiver stalls, the buffer holds and req_ready drops once a
// result is pending that is not the last one, or the last one is not taken.
// Reset (synchronous) returns the framer to the data phase, clears the
// annotation length, overflow flag and chunk byte count, and empties the
// output buffer; the block is ready in the first cycle after reset.
module annotation_stream_splitter #(
   parameter int MAX_ANNOT = asp_pkg::DEF_MAX_ANNOT,
   parameter int MAX_CHUNK = asp_pkg::DEF_MAX_CHUNK
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  asp_pkg::asp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output asp_pkg::asp_rsp_type rsp_data
);

   asp_pkg::asp_batch_type batch;
   logic                   accept;

   assign accept = req_valid && req_ready;

   asp_parse #(
      .MAX_ANNOT (MAX_ANNOT),
      .MAX_CHUNK (MAX_CHUNK)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .req    (req_data),
      .accept (accept),
      .batch  (batch)
   );

   asp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .load      (accept),
      .can_load  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/asp_parse.sv -----
`timescale 1ns / 1ps

module asp_parse #(
   parameter int MAX_ANNOT = asp_pkg::DEF_MAX_ANNOT,
   parameter int MAX_CHUNK = asp_pkg::DEF_MAX_CHUNK
) (
   input  logic                  clock,
   input  logic                  reset,
   input  asp_pkg::asp_req_type  req,
   input  logic                  accept,
   output asp_pkg::asp_batch_type batch
);

   localparam int ANNOT_W    = $clog2(MAX_ANNOT + 1);
   localparam int CountLimit = (MAX_CHUNK < asp_pkg::COUNT_CAP) ? MAX_CHUNK
                                                                : asp_pkg::COUNT_CAP;

   typedef enum logic [5:0] {
      PH_DATA = 6'b000001,
      PH_CR   = 6'b000010,
      PH_NL   = 6'b000100,
      PH_CZ   = 6'b001000,
      PH_ANN  = 6'b010000,
      PH_NLD  = 6'b100000
   } asp_phase_type;

   asp_phase_type                   phase_ff, phase_in;
   logic [ANNOT_W-1:0]              annot_len_ff, annot_len_in;
   logic                            annot_ovf_ff, annot_ovf_in;
   logic [asp_pkg::COUNT_W-1:0]     data_count_ff, data_count_in;

   logic [asp_pkg::MAX_HELD-1:0][7:0] dbyte;
   logic [asp_pkg::NDATA_W-1:0]       n_data;
   logic                              ann_store, ann_end;
   logic                              is_cr, is_lf, is_sub;
   logic                              store_ok;
   logic [asp_pkg::COUNT_W:0]         dc_sum;
   logic [asp_pkg::COUNT_W-1:0]       dc_sat;
   logic [asp_pkg::NRES_W-1:0]        n;
   logic [7:0]                        b;

   assign b      = req.in_byte;
   assign is_cr  = (b == asp_pkg::CH_CR);
   assign is_lf  = (b == asp_pkg::CH_LF);
   assign is_sub = (b == asp_pkg::CH_SUB);

   // frame decode: next phase, held bytes released as data, annotation action
   always_comb begin
      phase_in  = phase_ff;
      dbyte     = '0;
      n_data    = '0;
      ann_store = 1'b0;
      ann_end   = 1'b0;
      case (phase_ff)
         PH_CR: begin
            if (is_cr) begin
               n_data = 3'd1; dbyte[0] = asp_pkg::CH_CR;
            end else if (is_lf) begin
               phase_in = PH_NL;
            end else begin
               phase_in = PH_DATA;
               n_data = 3'd2; dbyte[0] = asp_pkg::CH_CR; dbyte[1] = b;
            end
         end
         PH_NL: begin
            dbyte[0] = asp_pkg::CH_CR;
            dbyte[1] = asp_pkg::CH_LF;
            if (is_cr) begin
               phase_in = PH_CR; n_data = 3'd2;
            end else if (is_lf) begin
               phase_in = PH_DATA; n_data = 3'd2;
            end else if (is_sub) begin
               phase_in = PH_CZ;
            end else begin
               phase_in = PH_DATA; n_data = 3'd3; dbyte[2] = b;
            end
         end
         PH_CZ: begin
            dbyte[0] = asp_pkg::CH_CR;
            dbyte[1] = asp_pkg::CH_LF;
            dbyte[2] = asp_pkg::CH_SUB;
            if (is_cr) begin
               phase_in = PH_CR; n_data = 3'd3;
            end else if (is_lf) begin
               phase_in = PH_DATA; n_data = 3'd3;
            end else if (is_sub) begin
               phase_in = PH_ANN;
            end else begin
               phase_in = PH_DATA; n_data = 3'd4; dbyte[3] = b;
            end
         end
         PH_ANN: begin
            if (is_lf) begin
               phase_in = PH_NLD; ann_end = 1'b1;
            end else begin
               ann_store = 1'b1;
            end
         end
         PH_NLD: begin
            if (is_cr) begin
               phase_in = PH_CR;
            end else if (is_lf) begin
               phase_in = PH_NL;
            end else if (is_sub) begin
               phase_in = PH_CZ;
            end else begin
               phase_in = PH_DATA; n_data = 3'd1; dbyte[0] = b;
            end
         end
         default: begin
            if (is_cr) begin
               phase_in = PH_CR;
            end else begin
               phase_in = PH_DATA; n_data = 3'd1; dbyte[0] = b;
            end
         end
      endcase
   end

   assign store_ok = (annot_len_ff < ANNOT_W'(MAX_ANNOT));

   // data count saturates; chunk end reports the count after this byte's data
   assign dc_sum = {1'b0, data_count_ff} + (asp_pkg::COUNT_W + 1)'(n_data);
   assign dc_sat = (dc_sum > (asp_pkg::COUNT_W + 1)'(CountLimit))
                   ? asp_pkg::COUNT_W'(CountLimit) : dc_sum[asp_pkg::COUNT_W-1:0];

   always_comb begin
      annot_len_in  = annot_len_ff;
      annot_ovf_in  = annot_ovf_ff;
      data_count_in = req.chunk_last ? '0 : dc_sat;
      if (ann_end) begin
         annot_len_in = '0;
         annot_ovf_in = 1'b0;
      end else if (ann_store) begin
         if (store_ok) annot_len_in = annot_len_ff + 1'b1;
         else          annot_ovf_in = 1'b1;
      end
   end

   always_comb begin
      batch = '0;
      n     = '0;
      for (int i = 0; i < asp_pkg::MAX_HELD; i++) begin
         if ((asp_pkg::NDATA_W)'(i) < n_data) begin
            batch.slot[i].kind     = asp_pkg::KIND_DATA;
            batch.slot[i].out_byte = dbyte[i];
         end
      end
      n = n_data;
      if (ann_end) begin
         batch.slot[n].kind     = asp_pkg::KIND_ANNOT_END;
         batch.slot[n].count    = asp_pkg::COUNT_W'(annot_len_ff);
         batch.slot[n].overflow = annot_ovf_ff;
         n = n + 1'b1;
      end else if (ann_store && store_ok) begin
         batch.slot[n].kind     = asp_pkg::KIND_ANNOT;
         batch.slot[n].out_byte = b;
         n = n + 1'b1;
      end
      if (req.chunk_last) begin
         batch.slot[n].kind  = asp_pkg::KIND_CHUNK_END;
         batch.slot[n].count = dc_sat;
         n = n + 1'b1;
      end
      if (n != '0) batch.slot[n - 1'b1].last = 1'b1;
      batch.cnt = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DATA;
         annot_len_ff  <= '0;
         annot_ovf_ff  <= 1'b0;
         data_count_ff <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         annot_len_ff  <= annot_len_in;
         annot_ovf_ff  <= annot_ovf_in;
         data_count_ff <= data_count_in;
      end
   end

endmodule

// ----- hdl/asp_outq.sv -----
`timescale 1ns / 1ps

module asp_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  asp_pkg::asp_batch_type batch,
   input  logic                   load,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output asp_pkg::asp_rsp_type   rsp_data
);

   asp_pkg::asp_rsp_type [asp_pkg::MAX_RESULTS-1:0] q_ff, q_in;
   logic [asp_pkg::NRES_W-1:0]                      cnt_ff, cnt_in;
   logic                                            pop;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = q_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   // a new batch may enter as the last pending result leaves
   assign can_load  = (cnt_ff == '0) || ((cnt_ff == 3'd1) && rsp_ready);

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (load && (batch.cnt != '0)) begin
         q_in   = batch.slot;
         cnt_in = batch.cnt;
      end else if (pop) begin
         for (int i = 0; i < asp_pkg::MAX_RESULTS - 1; i++) q_in[i] = q_ff[i+1];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

endmodule

// ----- tb/annotation_stream_splitter_tb.sv -----
`timescale 1ns / 1ps

module annotation_stream_splitter_tb;
   import asp_pkg::*;

   localparam int ANNOT_CAP   = DEF_MAX_ANNOT;
   localparam int CHUNK_CAP   = DEF_MAX_CHUNK;
   localparam int COUNT_TOP   = (CHUNK_CAP < COUNT_CAP) ? CHUNK_CAP : COUNT_CAP;
   localparam int RAND_ITEMS  = 130;
   localparam int HOLD_AT     = 60;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic [2:0] {
      FP_DATA, FP_CR, FP_CRLF, FP_SUB1, FP_ANNOT, FP_ANNOT_LF
   } frame_phase_type;

   typedef struct packed {
      asp_req_type   req;
      logic          given;
      asp_batch_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   asp_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   asp_rsp_type rsp_data;

   // predictor state
   frame_phase_type fr_phase;
   int              annot_len;
   logic            annot_ovf;
   int              data_cnt;

   asp_rsp_type step_res[$];
   asp_rsp_type pending_out[$];
   dir_row_type dir_tab[$];

   logic       no_idle   = 1'b0;
   int         errors    = 0;
   int         cycles    = 0;
   int         rand_sent = 0;
   logic [7:0] frame_head [4] = '{CH_CR, CH_LF, CH_SUB, CH_SUB};

   annotation_stream_splitter #(
      .MAX_ANNOT(ANNOT_CAP),
      .MAX_CHUNK(CHUNK_CAP)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic asp_rsp_type mk_rsp(input logic [1:0] k, input logic [7:0] b,
                                          input int c, input logic o,
                                          input logic l);
      asp_rsp_type r;
      r.kind     = k;
      r.out_byte = b;
      r.count    = COUNT_W'(c);
      r.overflow = o;
      r.last     = l;
      return r;
   endfunction

   function automatic void put_res(input logic [1:0] k, input logic [7:0] b,
                                   input int c, input logic o);
      step_res.push_back(mk_rsp(k, b, c, o, 1'b0));
   endfunction

   function automatic void put_data(input logic [7:0] b);
      put_res(KIND_DATA, b, 0, 1'b0);
      if (data_cnt < COUNT_TOP) data_cnt++;
   endfunction

   function automatic void put_annot(input logic [7:0] b);
      if (annot_len < ANNOT_CAP) begin
         annot_len++;
         put_res(KIND_ANNOT, b, 0, 1'b0);
      end else begin
         annot_ovf = 1'b1;
      end
   endfunction

   // framer prediction for one accepted transaction, results land in step_res
   task automatic split_byte(input asp_req_type t);
      logic [7:0]  b;
      asp_rsp_type tail;
      b = t.in_byte;
      step_res.delete();
      if (b == CH_CR) begin
         case (fr_phase)
            FP_CR: put_data(CH_CR);
            FP_CRLF: begin
               fr_phase = FP_CR;
               put_data(CH_CR); put_data(CH_LF);
            end
            FP_SUB1: begin
               fr_phase = FP_CR;
               put_data(CH_CR); put_data(CH_LF); put_data(CH_SUB);
            end
            FP_ANNOT: put_annot(b);
            default: fr_phase = FP_CR;
         endcase
      end else if (b == CH_LF) begin
         case (fr_phase)
            FP_CR, FP_ANNOT_LF: fr_phase = FP_CRLF;
            FP_CRLF: begin
               fr_phase = FP_DATA;
               put_data(CH_CR); put_data(CH_LF);
            end
            FP_SUB1: begin
               fr_phase = FP_DATA;
               put_data(CH_CR); put_data(CH_LF); put_data(CH_SUB);
            end
            FP_ANNOT: begin
               fr_phase = FP_ANNOT_LF;
               put_res(KIND_ANNOT_END, 8'h00, annot_len, annot_ovf);
               annot_len = 0;
               annot_ovf = 1'b0;
            end
            default: begin
               fr_phase = FP_DATA;
               put_data(CH_LF);
            end
         endcase
      end else if (b == CH_SUB) begin
         case (fr_phase)
            FP_CR: begin
               fr_phase = FP_DATA;
               put_data(CH_CR); put_data(CH_SUB);
            end
            FP_CRLF, FP_ANNOT_LF: fr_phase = FP_SUB1;
            FP_SUB1: fr_phase = FP_ANNOT;
            FP_ANNOT: put_annot(b);
            default: begin
               fr_phase = FP_DATA;
               put_data(CH_SUB);
            end
         endcase
      end else begin
         case (fr_phase)
            FP_CR: begin
               fr_phase = FP_DATA;
               put_data(CH_CR); put_data(b);
            end
            FP_CRLF: begin
               fr_phase = FP_DATA;
               put_data(CH_CR); put_data(CH_LF); put_data(b);
            end
            FP_SUB1: begin
               fr_phase = FP_DATA;
               put_data(CH_CR); put_data(CH_LF); put_data(CH_SUB); put_data(b);
            end
            FP_ANNOT: put_annot(b);
            default: begin
               fr_phase = FP_DATA;
               put_data(b);
            end
         endcase
      end
      if (t.chunk_last) begin
         put_res(KIND_CHUNK_END, 8'h00, data_cnt, 1'b0);
         data_cnt = 0;
      end
      if (step_res.size() > 0) begin
         tail = step_res.pop_back();
         tail.last = 1'b1;
         step_res.push_back(tail);
      end
   endtask

   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic logic maybe_last();
      return ($urandom_range(0, 11) == 0);
   endfunction

   // annotation text: any byte but LF, with CR and 0x1A mixed in
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0: b = CH_CR;
         1: b = CH_SUB;
         default: begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_LF) b = 8'h20;
         end
      endcase
      return b;
   endfunction

   function automatic dir_row_type plain_row(input logic [7:0] b, input logic cl);
      dir_row_type row;
      row = '0;
      row.req.in_byte    = b;
      row.req.chunk_last = cl;
      return row;
   endfunction

   function automatic dir_row_type known_row(input logic [7:0] b, input logic cl,
                                             input int n, input asp_rsp_type a,
                                             input asp_rsp_type z);
      dir_row_type row;
      row = plain_row(b, cl);
      row.given        = 1'b1;
      row.want.cnt     = NRES_W'(n);
      row.want.slot[0] = a;
      row.want.slot[1] = z;
      return row;
   endfunction

   task automatic send_req(input asp_req_type t, input logic given,
                           input asp_batch_type want);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      split_byte(t);
      if (given) begin
         for (int i = 0; i < want.cnt; i++) pending_out.push_back(want.slot[i]);
      end else begin
         foreach (step_res[i]) pending_out.push_back(step_res[i]);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic cl);
      asp_req_type t;
      t.in_byte    = b;
      t.chunk_last = cl;
      send_req(t, 1'b0, '0);
      rand_sent++;
   endtask

   // receiver: random stalls per result, one long hold-off to back up the input
   initial begin
      int   gap;
      int   seen;
      logic held;
      seen = 0;
      held = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && seen >= HOLD_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = idle_draw();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         seen++;
      end
   end

   always @(posedge clock) begin
      asp_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_out.size() == 0) begin
            if (errors < 10)
               $display("unexpected result: kind %0d byte %h count %0d ovf %0b last %0b",
                        rsp_data.kind, rsp_data.out_byte, rsp_data.count,
                        rsp_data.overflow, rsp_data.last);
            errors++;
         end else begin
            want = pending_out.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.out_byte !== want.out_byte ||
                rsp_data.count !== want.count || rsp_data.overflow !== want.overflow ||
                rsp_data.last !== want.last) begin
               if (errors < 10)
                  $display({"result mismatch: want kind %0d byte %h count %0d ovf %0b",
                            " last %0b, got kind %0d byte %h count %0d ovf %0b last %0b"},
                           want.kind, want.out_byte, want.count, want.overflow, want.last,
                           rsp_data.kind, rsp_data.out_byte, rsp_data.count,
                           rsp_data.overflow, rsp_data.last);
               errors++;
            end
         end
      end
   end

   initial begin
      int pick;
      int k;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      fr_phase  = FP_DATA;
      annot_len = 0;
      annot_ovf = 1'b0;
      data_cnt  = 0;

      dir_tab.push_back(known_row(8'h41, 1'b0, 1,
                                  mk_rsp(KIND_DATA, 8'h41, 0, 1'b0, 1'b1), '0));
      dir_tab.push_back(known_row(8'h00, 1'b1, 2,
                                  mk_rsp(KIND_DATA, 8'h00, 0, 1'b0, 1'b0),
                                  mk_rsp(KIND_CHUNK_END, 8'h00, 2, 1'b0, 1'b1)));
      dir_tab.push_back(known_row(8'hFF, 1'b0, 1,
                                  mk_rsp(KIND_DATA, 8'hFF, 0, 1'b0, 1'b1), '0));
      // well-formed frame with text containing CR and 0x1A
      dir_tab.push_back(plain_row(CH_CR, 1'b0));
      dir_tab.push_back(plain_row(CH_LF, 1'b0));
      dir_tab.push_back(plain_row(CH_SUB, 1'b0));
      dir_tab.push_back(plain_row(CH_SUB, 1'b0));
      dir_tab.push_back(known_row(8'h7F, 1'b0, 1,
                                  mk_rsp(KIND_ANNOT, 8'h7F, 0, 1'b0, 1'b1), '0));
      dir_tab.push_back(known_row(CH_CR, 1'b0, 1,
                                  mk_rsp(KIND_ANNOT, CH_CR, 0, 1'b0, 1'b1), '0));
      dir_tab.push_back(known_row(CH_SUB, 1'b0, 1,
                                  mk_rsp(KIND_ANNOT, CH_SUB, 0, 1'b0, 1'b1), '0));
      dir_tab.push_back(known_row(CH_LF, 1'b0, 1,
                                  mk_rsp(KIND_ANNOT_END, 8'h00, 3, 1'b0, 1'b1), '0));
      // back-to-back empty annotation closed together with the chunk
      dir_tab.push_back(plain_row(CH_LF, 1'b0));
      dir_tab.push_back(plain_row(CH_SUB, 1'b0));
      dir_tab.push_back(plain_row(CH_SUB, 1'b0));
      dir_tab.push_back(known_row(CH_LF, 1'b1, 2,
                                  mk_rsp(KIND_ANNOT_END, 8'h00, 0, 1'b0, 1'b0),
                                  mk_rsp(KIND_CHUNK_END, 8'h00, 1, 1'b0, 1'b1)));
      // broken frames, held bytes replayed as data
      dir_tab.push_back(plain_row(8'h80, 1'b0));
      dir_tab.push_back(plain_row(CH_CR, 1'b0));
      dir_tab.push_back(plain_row(CH_CR, 1'b0));
      dir_tab.push_back(plain_row(CH_SUB, 1'b0));
      dir_tab.push_back(plain_row(CH_CR, 1'b0));
      dir_tab.push_back(plain_row(CH_LF, 1'b0));
      dir_tab.push_back(plain_row(CH_CR, 1'b0));
      dir_tab.push_back(plain_row(CH_LF, 1'b0));
      dir_tab.push_back(plain_row(CH_SUB, 1'b0));
      // five results from one transaction
      dir_tab.push_back(plain_row(8'h01, 1'b1));
      dir_tab.push_back(plain_row(CH_LF, 1'b0));
      dir_tab.push_back(plain_row(CH_SUB, 1'b1));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].given, dir_tab[i].want);

      rand_sent = 0;
      while (rand_sent < RAND_ITEMS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), maybe_last());
         end else if (pick < 75) begin
            send_byte(CH_CR, maybe_last());
            send_byte(CH_LF, maybe_last());
            repeat ($urandom_range(1, 2)) begin
               send_byte(CH_SUB, maybe_last());
               send_byte(CH_SUB, maybe_last());
               repeat ($urandom_range(0, 10)) send_byte(text_byte(), maybe_last());
               send_byte(CH_LF, maybe_last());
            end
         end else begin
            k = $urandom_range(1, 3);
            for (int j = 0; j < k; j++) send_byte(frame_head[j], maybe_last());
            case ($urandom_range(0, 3))
               0: send_byte(CH_CR, maybe_last());
               1: send_byte(CH_LF, maybe_last());
               2: send_byte(CH_SUB, maybe_last());
               default: send_byte(8'($urandom_range(0, 255)), maybe_last());
            endcase
         end
      end

      // LF then a plain byte lands in the data phase from any phase
      no_idle = 1'b1;
      send_byte(CH_LF, 1'b0);
      send_byte(8'h7A, 1'b1);

      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
